// ===== design/size_budget_lru_object_cache_core_defines.svh =====
// Assertion macros shared by the cache core.
`ifndef SIZE_BUDGET_LRU_OBJECT_CACHE_CORE_DEFINES_SVH
`define SIZE_BUDGET_LRU_OBJECT_CACHE_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SBL_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SBL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/sblc_pkg.sv =====
`default_nettype none
package sblc_pkg;
  localparam int unsigned EntriesDef  = 64;
  localparam int unsigned SizeBitsDef = 40;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned SizeW       = 40;
  localparam int unsigned BudgetW     = 46;
  localparam int unsigned CntW        = 48;
  localparam int unsigned SmallW      = 7;

  localparam logic OpAccess = 1'b0;
  localparam logic OpQuery  = 1'b1;

  // Command word passed from the front to the back.
  typedef struct packed {
    logic             op;
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] size;
  } cmd_t;

  // Result word returned by the back.
  typedef struct packed {
    logic              hit;
    logic [SizeW-1:0]  entry_size;
    logic [SmallW-1:0] evicted_count;
    logic [CntW-1:0]   total_hits;
    logic [CntW-1:0]   total_misses;
    logic [CntW-1:0]   total_evictions;
    logic [BudgetW-1:0] bytes_in_use;
    logic [SmallW-1:0] entries_in_use;
  } res_t;
endpackage
`default_nettype wire

// ===== design/sblc_front.sv =====
`default_nettype none
// Front part: takes input words, masks the size and queues them for the back.
module sblc_front #(
  parameter int unsigned SizeBits = sblc_pkg::SizeBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [sblc_pkg::KeyW+sblc_pkg::SizeW-1:0] s_tdata_i,
  input  wire logic                  s_tuser_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output sblc_pkg::cmd_t             cmd_o
);
  localparam logic [sblc_pkg::SizeW-1:0] SizeMask =
    sblc_pkg::SizeW'((64'd1 << SizeBits) - 64'd1);

  // Two-entry queue.
  sblc_pkg::cmd_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  sblc_pkg::cmd_t in_cmd;
  logic push, pop;

  always_comb begin
    in_cmd.op   = s_tuser_i;
    in_cmd.key  = s_tdata_i[sblc_pkg::KeyW-1:0];
    in_cmd.size = s_tdata_i[sblc_pkg::KeyW+sblc_pkg::SizeW-1:sblc_pkg::KeyW] & SizeMask;
  end

  assign s_tready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign push = s_tvalid_i && s_tready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== design/sblc_back.sv =====
`default_nettype none
// Back part: sequencer that scans the table one entry a cycle.
module sblc_back #(
  parameter int unsigned Entries = sblc_pkg::EntriesDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [sblc_pkg::BudgetW-1:0] max_bytes_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire sblc_pkg::cmd_t        cmd_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output sblc_pkg::res_t             res_o
);
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned NW   = $clog2(Entries + 1);
  localparam int unsigned BytesW = (sblc_pkg::SizeW + NW > sblc_pkg::BudgetW) ?
                                   sblc_pkg::SizeW + NW : sblc_pkg::BudgetW + 1;
  localparam logic [NW-1:0] NFull = NW'(Entries);
  localparam logic [IdxW-1:0] Last = IdxW'(Entries - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLook   = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StAge    = 3'd3;
  localparam logic [2:0] StIns    = 3'd4;
  localparam logic [2:0] StChk    = 3'd5;
  localparam logic [2:0] StFind   = 3'd6;
  localparam logic [2:0] StDone   = 3'd7;

  // Table storage: keys, sizes and ranks in memories, valid bits in flops.
  logic [sblc_pkg::KeyW-1:0]  key_mem  [Entries];
  logic [sblc_pkg::SizeW-1:0] size_mem [Entries];
  logic [IdxW-1:0]            rank_mem [Entries];

  // Registered read data for the address issued in the previous cycle.
  logic [sblc_pkg::KeyW-1:0]  key_rd_q;
  logic [sblc_pkg::SizeW-1:0] size_rd_q;
  logic [IdxW-1:0]            rank_rd_q;

  logic [Entries-1:0] valid_q, valid_d;
  logic [2:0] st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d, pidx_q, pidx_d;
  logic iss_q, iss_d, pv_q, pv_d;
  sblc_pkg::cmd_t cmd_q, cmd_d;
  logic hit_q, hit_d, free_ok_q, free_ok_d, vict_ok_q, vict_ok_d;
  logic [IdxW-1:0] hidx_q, hidx_d, hrank_q, hrank_d;
  logic [IdxW-1:0] free_q, free_d, vict_q, vict_d;
  logic [sblc_pkg::SizeW-1:0] vsize_q, vsize_d, esize_q, esize_d;
  logic [sblc_pkg::SmallW-1:0] evc_q, evc_d;
  logic [BytesW-1:0] bytes_q, bytes_d;
  logic [NW-1:0] ents_q, ents_d;
  logic [sblc_pkg::CntW-1:0] hits_q, hits_d, miss_q, miss_d, evs_q, evs_d;
  logic out_v_q, out_v_d;
  sblc_pkg::res_t res_q, res_d;

  logic rank_we, ins_we;
  logic [IdxW-1:0] rank_wa, rank_wd;
  logic cur_valid;
  logic [IdxW-1:0] lru_rank;
  logic over;

  assign cur_valid = valid_q[pidx_q];
  assign lru_rank = IdxW'(ents_q - NW'(1));
  assign over = (max_bytes_i != '0) && (bytes_q > BytesW'(max_bytes_i)) &&
                (ents_q != '0);

  assign cmd_ready_o = (st_q == StIdle);
  assign res_valid_o = out_v_q;
  assign res_o = res_q;

  // Table memories: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[idx_q];
    size_rd_q <= size_mem[idx_q];
    rank_rd_q <= rank_mem[idx_q];
    if (rank_we) begin
      rank_mem[rank_wa] <= rank_wd;
    end
    if (ins_we) begin
      key_mem[free_q]  <= cmd_q.key;
      size_mem[free_q] <= cmd_q.size;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    st_d = st_q; idx_d = idx_q; iss_d = iss_q; pv_d = iss_q; pidx_d = idx_q;
    cmd_d = cmd_q; hit_d = hit_q; free_ok_d = free_ok_q; vict_ok_d = vict_ok_q;
    hidx_d = hidx_q; hrank_d = hrank_q; free_d = free_q; vict_d = vict_q;
    vsize_d = vsize_q; esize_d = esize_q; evc_d = evc_q; bytes_d = bytes_q;
    ents_d = ents_q; hits_d = hits_q; miss_d = miss_q; evs_d = evs_q;
    valid_d = valid_q; res_d = res_q;
    out_v_d = out_v_q && !res_ready_i;
    rank_we = 1'b0; rank_wa = pidx_q; rank_wd = '0; ins_we = 1'b0;

    // Address issue for a table pass.
    if (iss_q) begin
      if (idx_q == Last) iss_d = 1'b0;
      else idx_d = idx_q + IdxW'(1);
    end

    case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i; hit_d = 1'b0; free_ok_d = 1'b0; vict_ok_d = 1'b0;
          evc_d = '0; idx_d = '0; iss_d = 1'b1;
          st_d = StLook;
        end
      end
      // Key search, free slot search and least recent search in one pass.
      StLook: begin
        if (pv_q) begin
          if (cur_valid && key_rd_q == cmd_q.key) begin
            hit_d = 1'b1; hidx_d = pidx_q; hrank_d = rank_rd_q; esize_d = size_rd_q;
          end
          if (!cur_valid && !free_ok_q) begin
            free_ok_d = 1'b1; free_d = pidx_q;
          end
          if (cur_valid && rank_rd_q == lru_rank && !vict_ok_q) begin
            vict_ok_d = 1'b1; vict_d = pidx_q; vsize_d = size_rd_q;
          end
          if (pidx_q == Last) st_d = StDecide;
        end
      end
      // Count hits and access misses; an access miss on a full table drops the least recent entry.
      StDecide: begin
        if (hit_q) begin
          hits_d = hits_q + sblc_pkg::CntW'(1);
          if (cmd_q.op == sblc_pkg::OpQuery) st_d = StDone;
          else begin
            idx_d = '0; iss_d = 1'b1; st_d = StAge;
          end
        end else if (cmd_q.op == sblc_pkg::OpQuery) begin
          esize_d = '0; st_d = StDone;
        end else begin
          miss_d = miss_q + sblc_pkg::CntW'(1);
          esize_d = cmd_q.size;
          if (ents_q == NFull) begin
            valid_d[vict_q] = 1'b0;
            bytes_d = bytes_q - BytesW'(vsize_q);
            ents_d = ents_q - NW'(1);
            evs_d = evs_q + sblc_pkg::CntW'(1);
            evc_d = evc_q + sblc_pkg::SmallW'(1);
            free_d = vict_q;
          end
          idx_d = '0; iss_d = 1'b1; st_d = StAge;
        end
      end
      // Recency pass: a hit moves to the front, a miss pushes everyone back.
      StAge: begin
        if (pv_q) begin
          if (cur_valid) begin
            if (!hit_q) begin
              rank_we = 1'b1; rank_wd = rank_rd_q + IdxW'(1);
            end else if (pidx_q == hidx_q) begin
              rank_we = 1'b1; rank_wd = '0;
            end else if (rank_rd_q < hrank_q) begin
              rank_we = 1'b1; rank_wd = rank_rd_q + IdxW'(1);
            end
          end
          if (pidx_q == Last) st_d = hit_q ? StDone : StIns;
        end
      end
      // Write the new entry as most recent.
      StIns: begin
        ins_we = 1'b1;
        rank_we = 1'b1; rank_wa = free_q; rank_wd = '0;
        valid_d[free_q] = 1'b1;
        bytes_d = bytes_q + BytesW'(cmd_q.size);
        ents_d = ents_q + NW'(1);
        st_d = StChk;
      end
      // Budget check before each sweep step.
      StChk: begin
        if (over) begin
          idx_d = '0; iss_d = 1'b1; st_d = StFind;
        end else st_d = StDone;
      end
      // Budget sweep: locate and drop the least recent entry.
      StFind: begin
        if (pv_q) begin
          if (cur_valid && rank_rd_q == lru_rank) begin
            valid_d[pidx_q] = 1'b0;
            bytes_d = bytes_q - BytesW'(size_rd_q);
            ents_d = ents_q - NW'(1);
            evs_d = evs_q + sblc_pkg::CntW'(1);
            evc_d = evc_q + sblc_pkg::SmallW'(1);
            iss_d = 1'b0; pv_d = 1'b0; idx_d = '0;
            st_d = StChk;
          end else if (pidx_q == Last) st_d = StDone;
        end
      end
      StDone: begin
        if (!out_v_q) begin
          out_v_d = 1'b1;
          res_d.hit = hit_q;
          res_d.entry_size = esize_q;
          res_d.evicted_count = evc_q;
          res_d.total_hits = hits_q;
          res_d.total_misses = miss_q;
          res_d.total_evictions = evs_q;
          res_d.bytes_in_use = (bytes_q[BytesW-1:sblc_pkg::BudgetW] != '0) ?
            '1 : bytes_q[sblc_pkg::BudgetW-1:0];
          res_d.entries_in_use = sblc_pkg::SmallW'(ents_q);
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; idx_q <= '0; iss_q <= 1'b0; pv_q <= 1'b0; pidx_q <= '0;
      cmd_q <= '0; hit_q <= 1'b0; free_ok_q <= 1'b0; vict_ok_q <= 1'b0;
      hidx_q <= '0; hrank_q <= '0; free_q <= '0; vict_q <= '0;
      vsize_q <= '0; esize_q <= '0; evc_q <= '0; bytes_q <= '0; ents_q <= '0;
      hits_q <= '0; miss_q <= '0; evs_q <= '0; valid_q <= '0;
      out_v_q <= 1'b0; res_q <= '0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; iss_q <= iss_d; pv_q <= pv_d; pidx_q <= pidx_d;
      cmd_q <= cmd_d; hit_q <= hit_d; free_ok_q <= free_ok_d; vict_ok_q <= vict_ok_d;
      hidx_q <= hidx_d; hrank_q <= hrank_d; free_q <= free_d; vict_q <= vict_d;
      vsize_q <= vsize_d; esize_q <= esize_d; evc_q <= evc_d; bytes_q <= bytes_d;
      ents_q <= ents_d; hits_q <= hits_d; miss_q <= miss_d; evs_q <= evs_d;
      valid_q <= valid_d; out_v_q <= out_v_d; res_q <= res_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/size_budget_lru_object_cache_core.sv =====
`default_nettype none
// Size-aware LRU object table keyed by a 64-bit hash, with a byte budget
// register. One word is processed at a time by passes over the table that read
// one entry a cycle with registered data. A query makes one pass, an access
// hit a second pass to reorder recency, and an access miss also writes the new
// entry after its second pass; each entry removed to meet the budget takes a
// search of up to one more pass. Two input words are buffered.
`include "size_budget_lru_object_cache_core_defines.svh"
module size_budget_lru_object_cache_core #(
  parameter int unsigned Entries  = sblc_pkg::EntriesDef,
  parameter int unsigned SizeBits = sblc_pkg::SizeBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        max_bytes_we_i,
  input  wire logic [45:0] max_bytes_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // key [63:0], object_size [103:64]
  input  wire logic [103:0] s_axis_tdata,
  // operation
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // entry_size [39:0], evicted_count [46:40], total_hits [94:47],
  // total_misses [142:95], total_evictions [190:143], bytes_in_use [236:191],
  // entries_in_use [243:237], zeros [247:244]
  output logic [247:0]     m_axis_tdata,
  // hit
  output logic             m_axis_tuser
);
  logic [45:0] max_q;
  logic cmd_valid, cmd_ready;
  sblc_pkg::cmd_t cmd;
  sblc_pkg::res_t res;

  // Budget register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_q <= '0;
    else if (max_bytes_we_i) max_q <= max_bytes_i;
  end

  sblc_front #(.SizeBits(SizeBits)) u_front (
    .clk_i, .rst_ni, .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sblc_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni, .max_bytes_i(max_q), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .cmd_i(cmd), .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {4'd0, res.entries_in_use, res.bytes_in_use,
                         res.total_evictions, res.total_misses, res.total_hits,
                         res.evicted_count, res.entry_size};

  `SBL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
  `SBL_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, m_axis_tvalid,
                   32'(m_axis_tdata[243:237]) <= 32'(Entries), "entry count out of range")
endmodule
`default_nettype wire

// ===== dv/size_budget_lru_object_cache_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module size_budget_lru_object_cache_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         max_bytes_we_i,
  input  wire logic [45:0]  max_bytes_i,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [247:0] m_axis_tdata,
  input  wire logic         m_axis_tuser,
  output int                errors_o,
  output int                outstanding_o
);
  localparam int Slots = sblc_pkg::EntriesDef;

  // Shadow copy of the table and its counters.
  logic                          slot_live [Slots];
  logic [sblc_pkg::KeyW-1:0]     slot_key  [Slots];
  logic [sblc_pkg::SizeW-1:0]    slot_bytes[Slots];
  int                            slot_age  [Slots];
  logic [63:0]                   bytes_held;
  int                            slots_held;
  logic [sblc_pkg::CntW-1:0]     hit_tally, miss_tally, evict_tally;
  logic [sblc_pkg::BudgetW-1:0]  byte_budget;

  sblc_pkg::res_t expected_words[$];

  // Drops one entry and closes the gap in the age order behind it.
  task automatic drop_slot(input int s);
    int r;
    r = slot_age[s];
    slot_live[s] = 1'b0;
    bytes_held = bytes_held - slot_bytes[s];
    slots_held--;
    for (int i = 0; i < Slots; i++)
      if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
    evict_tally = evict_tally + 1'b1;
  endtask

  function automatic int oldest_slot();
    for (int i = 0; i < Slots; i++)
      if (slot_live[i] && slot_age[i] == slots_held - 1) return i;
    return -1;
  endfunction

  // Applies one lookup word to the shadow table and returns the result word.
  task automatic apply_lookup(input logic op, input logic [sblc_pkg::KeyW-1:0] key,
                              input logic [sblc_pkg::SizeW-1:0] size,
                              output sblc_pkg::res_t r);
    int s;
    int v;
    int r0;
    int dropped;
    s = -1;
    dropped = 0;
    r = '0;
    for (int i = 0; i < Slots; i++)
      if (s < 0 && slot_live[i] && slot_key[i] == key) s = i;
    if (s >= 0) begin
      r.hit = 1'b1;
      r.entry_size = slot_bytes[s];
      hit_tally = hit_tally + 1'b1;
      if (op == sblc_pkg::OpAccess) begin
        r0 = slot_age[s];
        for (int i = 0; i < Slots; i++)
          if (slot_live[i] && slot_age[i] < r0) slot_age[i]++;
        slot_age[s] = 0;
      end
    end else if (op == sblc_pkg::OpAccess) begin
      miss_tally = miss_tally + 1'b1;
      r.entry_size = size;
      // A full table gives up its oldest entry before the insert.
      if (slots_held >= Slots) begin
        v = oldest_slot();
        if (v >= 0) begin
          drop_slot(v);
          dropped++;
        end
      end
      s = -1;
      for (int i = 0; i < Slots; i++)
        if (s < 0 && !slot_live[i]) s = i;
      if (s >= 0) begin
        for (int i = 0; i < Slots; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_live[s] = 1'b1;
        slot_key[s] = key;
        slot_bytes[s] = size;
        slot_age[s] = 0;
        bytes_held = bytes_held + size;
        slots_held++;
      end
      // Budget sweep from the oldest end; the new entry may go too.
      while (byte_budget != 0 && bytes_held > byte_budget && slots_held > 0) begin
        v = oldest_slot();
        if (v < 0) break;
        drop_slot(v);
        dropped++;
      end
    end
    r.evicted_count = dropped[sblc_pkg::SmallW-1:0];
    r.total_hits = hit_tally;
    r.total_misses = miss_tally;
    r.total_evictions = evict_tally;
    r.bytes_in_use = (bytes_held > 64'h3FFF_FFFF_FFFF) ? '1 :
                     bytes_held[sblc_pkg::BudgetW-1:0];
    r.entries_in_use = slots_held[sblc_pkg::SmallW-1:0];
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors_o++;
      if (errors_o <= 10)
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Watch both channels; the older word is retired before a new one is queued.
  always @(posedge clk_i or negedge rst_ni) begin
    sblc_pkg::res_t want;
    sblc_pkg::res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) slot_live[i] = 1'b0;
      bytes_held = '0;
      slots_held = 0;
      hit_tally = '0;
      miss_tally = '0;
      evict_tally = '0;
      byte_budget = '0;
      expected_words.delete();
      errors_o = 0;
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("%0t: result word with nothing expected", $realtime);
        end else begin
          want = expected_words.pop_front();
          got.hit = m_axis_tuser;
          got.entry_size = m_axis_tdata[39:0];
          got.evicted_count = m_axis_tdata[46:40];
          got.total_hits = m_axis_tdata[94:47];
          got.total_misses = m_axis_tdata[142:95];
          got.total_evictions = m_axis_tdata[190:143];
          got.bytes_in_use = m_axis_tdata[236:191];
          got.entries_in_use = m_axis_tdata[243:237];
          check_field("hit", want.hit, got.hit);
          check_field("entry_size", want.entry_size, got.entry_size);
          check_field("evicted_count", want.evicted_count, got.evicted_count);
          check_field("total_hits", want.total_hits, got.total_hits);
          check_field("total_misses", want.total_misses, got.total_misses);
          check_field("total_evictions", want.total_evictions, got.total_evictions);
          check_field("bytes_in_use", want.bytes_in_use, got.bytes_in_use);
          check_field("entries_in_use", want.entries_in_use, got.entries_in_use);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_lookup(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[103:64], want);
        expected_words = {expected_words, want};
      end
      if (max_bytes_we_i) byte_budget = max_bytes_i;
      outstanding_o = expected_words.size();
    end
  end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int StallLimit = 40000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         max_bytes_we_i = 1'b0;
  logic [45:0]  max_bytes_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [247:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           errors;
  int           outstanding;

  logic [sblc_pkg::KeyW-1:0] key_pool[96];
  bit              calm = 1'b0;
  int              sink_stall = 0;
  int              quiet_cycles = 0;

  size_budget_lru_object_cache_core dut (.*);

  size_budget_lru_object_cache_checker checker_i (
    .clk_i, .rst_ni, .max_bytes_we_i, .max_bytes_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .outstanding_o(outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: ready drops in short random bursts until the calm tail.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one word from a falling edge and holds it until accepted.
  task automatic send_word(input logic op, input logic [sblc_pkg::KeyW-1:0] key,
                           input logic [sblc_pkg::SizeW-1:0] size);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {size, key};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Budget writes only once every outstanding word has come back.
  task automatic set_budget(input logic [45:0] value);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    max_bytes_we_i <= 1'b1;
    max_bytes_i <= value;
    @(negedge clk_i);
    max_bytes_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly pool keys so that hits and recency reordering are common.
  task automatic random_words(input int count, input int size_cap);
    logic                       op;
    logic [sblc_pkg::KeyW-1:0]  key;
    logic [sblc_pkg::SizeW-1:0] size;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 3) == 0) ? sblc_pkg::OpQuery : sblc_pkg::OpAccess;
      key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(0, 95)];
      size = ($urandom_range(0, 4) == 0) ? {8'($urandom), 32'($urandom)}
                                         : sblc_pkg::SizeW'($urandom_range(0, size_cap));
      send_word(op, key, size);
    end
  endtask

  initial begin
    for (int i = 0; i < 96; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Unbounded budget: misses, hits, queries and full-table replacement.
    set_budget('0);
    send_word(sblc_pkg::OpQuery, '0, '0);
    send_word(sblc_pkg::OpAccess, '0, '0);
    send_word(sblc_pkg::OpAccess, '1, '1);
    send_word(sblc_pkg::OpAccess, '0, 40'd123);
    send_word(sblc_pkg::OpQuery, '1, '0);
    send_word(sblc_pkg::OpQuery, 64'h5555_AAAA_5555_AAAA, 40'd1);
    random_words(300, 100000);

    // Largest budget never forces an eviction.
    set_budget('1);
    random_words(150, 1000000);

    // Full table of empty objects, then one object over the budget: every entry goes.
    set_budget(46'd1);
    for (int i = 0; i < 64; i++) send_word(sblc_pkg::OpAccess, 64'hC000_0000 + i, '0);
    send_word(sblc_pkg::OpAccess, 64'hD000_0000, 40'd5);
    send_word(sblc_pkg::OpAccess, 64'hD000_0001, 40'd1);

    // Tight budget: steady sweeps, big objects evicted on their own.
    set_budget(46'd5000);
    random_words(250, 3000);

    set_budget({14'($urandom), 32'($urandom)});
    random_words(100, 1 << 30);
    calm = 1'b1;
    random_words(100, 1 << 30);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
